@@ rtl/xor_checksum_line_checker_assert.svh @@
// Assertion macros for the XOR checksum line checker.
`ifndef XOR_CHECKSUM_LINE_CHECKER_ASSERT_SVH
`define XOR_CHECKSUM_LINE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define XCS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on aclk outside reset.
`define XCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/xcs_pkg.sv @@
// Shared constants, types and helpers for the XOR checksum line checker.
package xcs_pkg;

    localparam logic [7:0] CHAR_EOL  = 8'h00;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] HEX_A_VAL = 8'd10;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONE     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_SYNTAX   = 2'd3
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] checksum;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    // Uppercase hex digit decode; ok low for anything else.
    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t       h;
        logic [7:0] diff;
        h = '0;
        diff = '0;
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
            diff = ch - CHAR_0;
            h.ok = 1'b1;
            h.nibble = diff[3:0];
        end else if (ch >= CHAR_A && ch <= CHAR_F) begin
            diff = ch - CHAR_A + HEX_A_VAL;
            h.ok = 1'b1;
            h.nibble = diff[3:0];
        end
        return h;
    endfunction

endpackage

@@ rtl/xcs_core.sv @@
// Line parser state machine: XOR accumulator, checksum digits and status.
module xcs_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [7:0]       char_in,
    output xcs_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_PAYLOAD = 3'd1,
        PH_HEX1    = 3'd2,
        PH_HEX2    = 3'd3,
        PH_END     = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    phase_t        phase_reg;
    logic [7:0]    xor_reg;
    logic [3:0]    hi_reg;
    logic [7:0]    rx_reg;
    xcs_pkg::hex_t hex;

    assign hex = xcs_pkg::hex_decode(char_in);

    // Result seen by the terminator, from the state before it.
    always_comb begin
        result.checksum = xor_reg;
        unique case (phase_reg) inside
            PH_SKIP, PH_PAYLOAD: result.status = xcs_pkg::ST_NONE;
            PH_END: result.status = (xor_reg == rx_reg) ? xcs_pkg::ST_OK
                                                        : xcs_pkg::ST_MISMATCH;
            default: result.status = xcs_pkg::ST_SYNTAX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            xor_reg   <= '0;
            hi_reg    <= '0;
            rx_reg    <= '0;
        end else if (step_en) begin
            if (char_in == xcs_pkg::CHAR_EOL) begin
                phase_reg <= PH_SKIP;
                xor_reg   <= '0;
                hi_reg    <= '0;
                rx_reg    <= '0;
            end else begin
                unique case (phase_reg)
                    PH_SKIP: phase_reg <= PH_PAYLOAD;
                    PH_PAYLOAD: begin
                        if (char_in == xcs_pkg::CHAR_STAR) begin
                            phase_reg <= PH_HEX1;
                        end else begin
                            xor_reg <= xor_reg ^ char_in;
                        end
                    end
                    PH_HEX1: begin
                        if (hex.ok) begin
                            hi_reg    <= hex.nibble;
                            phase_reg <= PH_HEX2;
                        end else begin
                            phase_reg <= PH_ERROR;
                        end
                    end
                    PH_HEX2: begin
                        if (hex.ok) begin
                            rx_reg    <= {hi_reg, hex.nibble};
                            phase_reg <= PH_END;
                        end else begin
                            phase_reg <= PH_ERROR;
                        end
                    end
                    default: phase_reg <= PH_ERROR;
                endcase
            end
        end
    end

endmodule

@@ rtl/xor_checksum_line_checker.sv @@
// Top level of the XOR checksum line checker: input stage, parser, result register.
//   channel   dir   ports                                   carries
//   s_        in    s_valid s_ready s_char_in               one line character per item
//   m_        out   m_valid m_ready m_status                one result item per line
//                   m_computed_checksum
// One item per cycle sustained unless the input stage is held; a character waits in the
// input register to be parsed; a parsed terminator's result goes to the output register.
// m_valid comes from the output valid register, set when the parser takes a terminator.
// Only a terminator meeting a full, stalled output register holds the input stage.
// aresetn is synchronous, active low; it clears the parser and both valid flags.
module xor_checksum_line_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_computed_checksum
);

    logic              in_vld_reg;
    logic [7:0]        in_char_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    xcs_pkg::result_t  out_res_reg;
    xcs_pkg::result_t  core_res;
    logic              is_term;
    logic              adv;

    assign is_term = (in_char_reg == xcs_pkg::CHAR_EOL);
    assign adv     = in_vld_reg && (!is_term || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;

    xcs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv),
        .char_in (in_char_reg),
        .result  (core_res)
    );

    always_comb begin
        out_vld_next = out_vld_reg;
        if (adv && is_term) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
        end
        if (adv && is_term) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_status            = out_res_reg.status;
    assign m_computed_checksum = out_res_reg.checksum;

`include "xor_checksum_line_checker_assert.svh"

    `XCS_ASSERT_NEXT(a_term_gives_result, adv && is_term, m_valid)
    `XCS_ASSERT_NEXT(a_no_result_from_char, adv && !is_term && (!m_valid || m_ready), !m_valid)
    `XCS_ASSERT_IMPLY(a_empty_stage_ready, !in_vld_reg, s_ready)
    `XCS_ASSERT_IMPLY(a_stall_only_on_term, in_vld_reg && !adv, is_term && m_valid && !m_ready)

endmodule
